// ===== rtl/core/mtep_pkg.sv =====
// Shared types, constants and the note-to-key table of the MIDI track event parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mtep_pkg;

  // field widths of the byte and result beats
  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned DeltaW = 32;
  localparam int unsigned TempoW = 24;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KIND_DELAY    = 3'd0,
    KIND_KEY_DOWN = 3'd1,
    KIND_KEY_UP   = 3'd2,
    KIND_PROGRAM  = 3'd3,
    KIND_TEMPO    = 3'd4,
    KIND_END      = 3'd5
  } kind_e;

  // status high nibbles that decode to a specific event
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_CHAN_AT  = 4'hD;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;

  localparam logic [ByteW-1:0] STATUS_META = 8'hFF;

  // meta event types with dedicated handling
  localparam logic [ByteW-1:0] META_END_TRACK = 8'h2F;
  localparam logic [ByteW-1:0] META_TEMPO     = 8'h51;
  localparam logic [ByteW-1:0] META_TIME_SIG  = 8'h58;
  localparam logic [ByteW-1:0] META_KEY_SIG   = 8'h59;

  localparam logic [ByteW-1:0] KEY_NONE = 8'h20;

  // one result beat
  typedef struct packed {
    kind_e             kind;
    logic [DeltaW-1:0] delta_ticks;
    logic [ByteW-1:0]  note_number;
    logic [ByteW-1:0]  key_code;
    logic [ByteW-1:0]  program_number;
    logic [TempoW-1:0] tempo_us;
  } res_t;

  // note number to keyboard letter, space when unmapped
  function automatic logic [ByteW-1:0] key_of(input logic [ByteW-1:0] note);
    logic [ByteW-1:0] k;
    case (note)
      8'h48:   k = "Q";
      8'h4a:   k = "W";
      8'h4c:   k = "E";
      8'h4d:   k = "R";
      8'h4f:   k = "T";
      8'h51:   k = "Y";
      8'h53:   k = "U";
      8'h3c:   k = "A";
      8'h3e:   k = "S";
      8'h40:   k = "D";
      8'h41:   k = "F";
      8'h43:   k = "G";
      8'h45:   k = "H";
      8'h47:   k = "J";
      8'h30:   k = "Z";
      8'h32:   k = "X";
      8'h34:   k = "C";
      8'h35:   k = "V";
      8'h37:   k = "B";
      8'h39:   k = "N";
      8'h3b:   k = "M";
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mtep_byte_if.sv =====
// Input channel of the MIDI track event parser: one track byte per beat.
// Depends on mtep_pkg for the byte width.
`default_nettype none

interface mtep_byte_if import mtep_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             track_start;

  modport source (output valid, output data_byte, output track_start, input ready);
  modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mtep_res_if.sv =====
// Output channel of the MIDI track event parser: one decoded event per beat.
// Depends on mtep_pkg for the field widths.
`default_nettype none

interface mtep_res_if import mtep_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [DeltaW-1:0] delta_ticks;
  logic [ByteW-1:0]  note_number;
  logic [ByteW-1:0]  key_code;
  logic [ByteW-1:0]  program_number;
  logic [TempoW-1:0] tempo_us;

  modport source (output valid, output kind, output delta_ticks, output note_number,
                  output key_code, output program_number, output tempo_us,
                  input ready);
  modport sink   (input valid, input kind, input delta_ticks, input note_number,
                  input key_code, input program_number, input tempo_us,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mtep_parser.sv =====
// Byte-level parse state machine: updates the parser state on each accepted byte
// and presents the result that byte causes. Depends on mtep_pkg.
`default_nettype none

module mtep_parser import mtep_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             track_start_i,
  output logic                  res_valid_o,
  output res_t                  res_o
);

  typedef enum logic [3:0] {
    PH_LEN   = 4'd0,
    PH_DELTA = 4'd1,
    PH_VLQ   = 4'd2,
    PH_KEY   = 4'd3,
    PH_PROG  = 4'd4,
    PH_MTYPE = 4'd5,
    PH_MLEN  = 4'd6,
    PH_TEMPO = 4'd7,
    PH_SKIP  = 4'd8,
    PH_DONE  = 4'd9
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              lwd_q, lwd_d;
  logic [ByteW-1:0]  skip_q, skip_d;
  logic [DeltaW-1:0] delta_q, delta_d;
  logic [TempoW-1:0] tempo_q, tempo_d;
  logic [ByteW-1:0]  meta_q, meta_d;
  logic [3:0]        hi_q, hi_d;

  logic [ByteW-1:0]  skip_dec;
  logic              skip_req;
  logic [ByteW-1:0]  skip_n;
  logic              vlq_req;
  logic [DeltaW-1:0] vlq_base;
  logic [DeltaW-1:0] vlq_acc;
  logic [3:0]        hi;

  assign hi       = data_byte_i[7:4];
  assign skip_dec = (skip_q != '0) ? skip_q - 8'd1 : '0;
  // a new delta starts from zero, a continued one from the accumulator
  assign vlq_base = (phase_q == PH_VLQ) ? delta_q : '0;
  // seven more bits of a delta; the shift drops the top bits
  assign vlq_acc  = {vlq_base[DeltaW-8:0], data_byte_i[6:0]};

  // next state and result for the current byte
  always_comb begin
    phase_d     = phase_q;
    lwd_d       = lwd_q;
    skip_d      = skip_q;
    delta_d     = delta_q;
    tempo_d     = tempo_q;
    meta_d      = meta_q;
    hi_d        = hi_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    skip_req    = 1'b0;
    skip_n      = '0;
    vlq_req     = 1'b0;

    if (accept_i) begin
      if (track_start_i) begin
        phase_d = PH_LEN;
        lwd_d   = 1'b0;
        skip_d  = 8'd3;
        delta_d = '0;
        tempo_d = '0;
        meta_d  = '0;
        hi_d    = '0;
      end else begin
        unique case (phase_q)
          PH_LEN: begin
            skip_d = skip_dec;
            if (skip_dec == '0) begin
              phase_d = PH_DELTA;
              lwd_d   = 1'b0;
            end
          end
          PH_DELTA: begin
            if (!lwd_q || !data_byte_i[7]) begin
              vlq_req = 1'b1;
            end else begin
              hi_d = hi;
              case (hi)
                HI_NOTE_OFF, HI_NOTE_ON: phase_d = PH_KEY;
                HI_PROGRAM:              phase_d = PH_PROG;
                HI_CHAN_AT: begin
                  skip_req = 1'b1;
                  skip_n   = 8'd1;
                end
                HI_SYSTEM: begin
                  if (data_byte_i == STATUS_META) begin
                    phase_d = PH_MTYPE;
                  end else begin
                    skip_req = 1'b1;
                    skip_n   = 8'd2;
                  end
                end
                default: begin
                  skip_req = 1'b1;
                  skip_n   = 8'd2;
                end
              endcase
            end
          end
          PH_VLQ: begin
            vlq_req = 1'b1;
          end
          PH_KEY: begin
            skip_req          = 1'b1;
            skip_n            = 8'd1;
            res_valid_o       = 1'b1;
            res_o.kind        = (hi_q == HI_NOTE_ON) ? KIND_KEY_DOWN : KIND_KEY_UP;
            res_o.note_number = data_byte_i;
            res_o.key_code    = key_of(data_byte_i);
          end
          PH_PROG: begin
            lwd_d                = 1'b0;
            phase_d              = PH_DELTA;
            res_valid_o          = 1'b1;
            res_o.kind           = KIND_PROGRAM;
            res_o.program_number = data_byte_i;
          end
          PH_MTYPE: begin
            meta_d  = data_byte_i;
            phase_d = PH_MLEN;
          end
          PH_MLEN: begin
            case (meta_q)
              META_END_TRACK: begin
                phase_d     = PH_DONE;
                lwd_d       = 1'b0;
                res_valid_o = 1'b1;
                res_o.kind  = KIND_END;
              end
              META_TEMPO: begin
                tempo_d = '0;
                skip_d  = 8'd3;
                phase_d = PH_TEMPO;
                lwd_d   = 1'b0;
              end
              META_TIME_SIG: begin
                skip_req = 1'b1;
                skip_n   = 8'd4;
              end
              META_KEY_SIG: begin
                skip_req = 1'b1;
                skip_n   = 8'd2;
              end
              default: begin
                skip_req = 1'b1;
                skip_n   = data_byte_i;
              end
            endcase
          end
          PH_TEMPO: begin
            tempo_d = {tempo_q[TempoW-9:0], data_byte_i};
            skip_d  = skip_dec;
            if (skip_dec == '0) begin
              phase_d        = PH_DELTA;
              res_valid_o    = 1'b1;
              res_o.kind     = KIND_TEMPO;
              res_o.tempo_us = {tempo_q[TempoW-9:0], data_byte_i};
            end
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == '0) phase_d = PH_DELTA;
          end
          PH_DONE: begin
            phase_d = PH_DONE;
          end
          default: begin
            phase_d = PH_DONE;
          end
        endcase

        // delta byte: accumulate, and finish on a clear top bit
        if (vlq_req) begin
          delta_d = vlq_acc;
          if (data_byte_i[7]) begin
            phase_d = PH_VLQ;
          end else begin
            phase_d           = PH_DELTA;
            lwd_d             = 1'b1;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_DELAY;
            res_o.delta_ticks = vlq_acc;
          end
        end

        // enter a byte skip, or go straight back to deltas when it is empty
        if (skip_req) begin
          lwd_d = 1'b0;
          if (skip_n == '0) begin
            phase_d = PH_DELTA;
          end else begin
            skip_d  = skip_n;
            phase_d = PH_SKIP;
          end
        end
      end
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      lwd_q   <= 1'b0;
      skip_q  <= 8'd4;
      delta_q <= '0;
      tempo_q <= '0;
      meta_q  <= '0;
      hi_q    <= '0;
    end else begin
      phase_q <= phase_d;
      lwd_q   <= lwd_d;
      skip_q  <= skip_d;
      delta_q <= delta_d;
      tempo_q <= tempo_d;
      meta_q  <= meta_d;
      hi_q    <= hi_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mtep_skid.sv =====
// Result register with a skid stage, so the parser keeps taking bytes while a
// result waits at the output. Depends on mtep_pkg for the result type.
`default_nettype none

module mtep_skid import mtep_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire res_t in_data_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output res_t      out_data_o,
  input  wire logic out_ready_i
);

  logic out_vld_q;
  logic skd_vld_q;
  res_t out_q;
  res_t skd_q;

  // room as long as the skid stage is empty
  assign in_ready_o  = !skd_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      if (skd_vld_q) begin
        out_vld_q <= 1'b1;
        skd_vld_q <= 1'b0;
      end else begin
        out_vld_q <= in_valid_i;
      end
    end else if (in_valid_i) begin
      skd_vld_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      out_q <= skd_vld_q ? skd_q : in_data_i;
    end else if (in_valid_i && !skd_vld_q) begin
      skd_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/midi_track_event_parser.sv =====
// MIDI track event parser, top level.
// Depends on mtep_pkg, mtep_byte_if, mtep_res_if, mtep_parser and mtep_skid.
//
// Usage: byte_i carries the raw bytes of a track chunk, one per beat. Raise
// track_start on the first of the four chunk length bytes; those are skipped
// and the body is decoded from the fifth byte on, without running status.
// result_o carries decoded events: delays, key down/up with note and key
// letter, program changes, tempo changes and end of track. Bytes after end of
// track are dropped until the next track_start.
// Throughput: one byte per cycle while byte_i.ready is high. The state update
// for a byte is a single pass through the parse state machine, and a byte
// yields at most one event. Output: the event that a byte completes is
// registered in the result register, via the skid entry if that register stalls.
// Stall: a result register plus one skid entry buffer events; byte_i.ready
// drops only while both are full, and nothing is lost or repeated.
// Reset: asynchronous, active low. The parser restarts in the length-skip
// phase with four bytes to skip, and both result entries are emptied.
`default_nettype none

module midi_track_event_parser import mtep_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mtep_byte_if.sink  byte_i,
  mtep_res_if.source result_o
);

  logic accept;
  logic res_valid;
  res_t res;
  res_t out_data;

  assign accept = byte_i.valid && byte_i.ready;

  // byte-level state machine
  mtep_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (byte_i.data_byte),
    .track_start_i (byte_i.track_start),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // result buffering toward the receiver
  mtep_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (byte_i.ready),
    .out_valid_o (result_o.valid),
    .out_data_o  (out_data),
    .out_ready_i (result_o.ready)
  );

  // result beat fields
  assign result_o.kind           = out_data.kind;
  assign result_o.delta_ticks    = out_data.delta_ticks;
  assign result_o.note_number    = out_data.note_number;
  assign result_o.key_code       = out_data.key_code;
  assign result_o.program_number = out_data.program_number;
  assign result_o.tempo_us       = out_data.tempo_us;

endmodule

`default_nettype wire
